// File: rtl/lzwve_pkg.sv
// Package for the LZW variable width encoder.
// Holds fixed code constants, the sequencer state type and the result entry type.
// No dependencies.
package lzwve_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int SYMBOL_BITS = 8;
    localparam int HASH_SLOTS = 8192;
    localparam logic [15:0] CODE_CLR = 16'd256;
    localparam logic [15:0] CODE_EOS = 16'd257;
    localparam logic [15:0] FIRST_FREE = 16'd258;
    localparam logic [4:0] START_WIDTH = 5'd9;
    localparam logic [3:0] CFG_RESET = 4'd12;

    typedef enum logic [4:0] {
        S_SWEEP = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_CMP   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic [15:0] code;
        logic [4:0]  width;
        logic        last;
    } t_res;

endpackage

// File: rtl/lzwve_dict.sv
// Dictionary memory of the LZW encoder: one write port, one registered read port.
// Uses no package items.
module lzwve_dict #(
    parameter int AW = 13,
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/lzw_variable_width_encoder.sv
// Top level of the LZW variable width encoder: sequencer, hashing and result queue.
// Depends on lzwve_pkg and lzwve_dict.
//
// Input channel (i_valid/o_ready) carries i_kind and i_data_byte; kind 1 ends a
// stream. Output channel (o_valid/i_ready) carries o_code, o_code_width and
// o_last_of_run, one transfer per code, one or two codes per item (none for
// a byte that only starts or extends the prefix in mid stream). i_cfg_we/i_cfg_data
// write max_code_width at any edge; write it only while idle.
// One item at a time: o_ready is high only while idle. A byte that extends
// an existing prefix is taken in the idle state, then costs one memory read and one
// compare per dictionary probe (linear probing from the hash slot); codes then
// leave one at a time from the output register. A stalled receiver holds the
// output register and the block waits.
// After reset, after every end item and after every dictionary clear the
// dictionary is swept, all HASH_SLOTS slots, one slot a cycle, with o_ready low.
module lzw_variable_width_encoder
    import lzwve_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [SYMBOL_BITS-1:0] i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_code,
    output logic [3:0]  o_code_width,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);
    localparam int MCB = MAX_CODE_BITS;
    localparam int SB = SYMBOL_BITS;
    localparam int AW = $clog2(HASH_SLOTS);
    localparam int CWB = $clog2(MAX_CODE_BITS + 1);
    localparam int KW = MCB + SB;
    localparam int DW = 2 * MCB + SB + 1;

    t_state         r_state, n_state;
    logic [3:0]     r_cfg;
    logic [MCB-1:0] r_prefix, n_prefix;
    logic           r_pv, n_pv;
    logic [MCB:0]   r_nf, n_nf;
    logic [CWB-1:0] r_cw, n_cw;
    logic           r_started, n_started;
    logic [SB-1:0]  r_byte, n_byte;
    logic [AW-1:0]  r_addr, n_addr;
    logic [AW-1:0]  r_probe, n_probe;
    logic [AW-1:0]  r_swp, n_swp;
    logic           r_clr_pend, n_clr_pend;
    t_res           r_q0, n_q0, r_q1, n_q1;
    logic           r_two, n_two;

    logic           mem_we, mem_re;
    logic [AW-1:0]  mem_waddr;
    logic [DW-1:0]  mem_wdata, mem_rdata;

    logic [CWB-1:0] emax;
    logic           rv, hit;
    logic [MCB-1:0] rp, rc;
    logic [SB-1:0]  rb;

    function automatic logic [AW-1:0] home_slot(input logic [MCB-1:0] pfx,
                                                input logic [SB-1:0] b);
        logic [KW-1:0] key;
        key = {pfx, b};
        key = key ^ (key >> 7);
        return AW'(key);
    endfunction

    lzwve_dict #(.AW(AW), .DW(DW)) u_dict (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        if ({1'b0, r_cfg} < START_WIDTH) begin
            emax = CWB'(START_WIDTH);
        end else if ({1'b0, r_cfg} > 5'(MCB)) begin
            emax = CWB'(MCB);
        end else begin
            emax = CWB'(r_cfg);
        end
    end

    assign rv = mem_rdata[DW-1];
    assign rp = mem_rdata[DW-2 -: MCB];
    assign rb = mem_rdata[MCB+SB-1:MCB];
    assign rc = mem_rdata[MCB-1:0];
    assign hit = rv && (rp == r_prefix) && (rb == r_byte);
    assign mem_re = (r_state == S_RD);

    always_comb begin
        logic k;
        t_res e;
        n_state = r_state;
        n_prefix = r_prefix;
        n_pv = r_pv;
        n_nf = r_nf;
        n_cw = r_cw;
        n_started = r_started;
        n_byte = r_byte;
        n_addr = r_addr;
        n_probe = r_probe;
        n_swp = r_swp;
        n_clr_pend = r_clr_pend;
        n_q0 = r_q0;
        n_q1 = r_q1;
        n_two = r_two;
        mem_we = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {1'b1, r_prefix, r_byte, MCB'(r_nf)};
        k = 1'b0;
        e = '0;
        case (r_state)
            S_SWEEP: begin
                mem_we = 1'b1;
                mem_waddr = r_swp;
                mem_wdata = '0;
                n_swp = r_swp + 1'b1;
                if (r_swp == {AW{1'b1}}) begin
                    n_clr_pend = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_two = 1'b0;
                    if (!r_started) begin
                        n_q0 = '{code: CODE_CLR, width: 5'(r_cw), last: 1'b1};
                        k = 1'b1;
                        n_started = 1'b1;
                    end
                    if (i_kind) begin
                        if (r_pv) begin
                            e = '{code: 16'(r_prefix), width: 5'(r_cw), last: 1'b0};
                            if (k) begin
                                n_q1 = e;
                                n_two = 1'b1;
                            end else begin
                                n_q0 = e;
                            end
                            k = 1'b1;
                        end
                        e = '{code: CODE_EOS, width: 5'(r_cw), last: 1'b1};
                        if (k) begin
                            n_q0.last = 1'b0;
                            n_q1 = e;
                            n_two = 1'b1;
                        end else begin
                            n_q0 = e;
                        end
                        n_started = 1'b0;
                        n_pv = 1'b0;
                        n_prefix = '0;
                        n_nf = (MCB+1)'(FIRST_FREE);
                        n_cw = CWB'(START_WIDTH);
                        n_clr_pend = 1'b1;
                        n_swp = '0;
                        n_state = S_OUT;
                    end else if (!r_pv) begin
                        n_prefix = MCB'(i_data_byte);
                        n_pv = 1'b1;
                        n_state = k ? S_OUT : S_IDLE;
                    end else begin
                        n_byte = i_data_byte;
                        n_addr = home_slot(r_prefix, i_data_byte);
                        n_probe = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    n_prefix = rc;
                    n_state = S_IDLE;
                end else if (!rv || (r_probe == {AW{1'b1}})) begin
                    mem_we = !rv;
                    n_q0 = '{code: 16'(r_prefix), width: 5'(r_cw), last: 1'b1};
                    n_two = 1'b0;
                    if (r_nf == ((MCB+1)'(1) << r_cw)) begin
                        if (r_cw >= emax) begin
                            n_q0.last = 1'b0;
                            n_q1 = '{code: CODE_CLR, width: 5'(r_cw), last: 1'b1};
                            n_two = 1'b1;
                            n_nf = (MCB+1)'(FIRST_FREE);
                            n_cw = CWB'(START_WIDTH);
                            n_clr_pend = 1'b1;
                            n_swp = '0;
                        end else begin
                            n_nf = r_nf + 1'b1;
                            n_cw = r_cw + 1'b1;
                        end
                    end else begin
                        n_nf = r_nf + 1'b1;
                    end
                    n_prefix = MCB'(r_byte);
                    n_pv = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_addr = r_addr + 1'b1;
                    n_probe = r_probe + 1'b1;
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_two) begin
                        n_q0 = r_q1;
                        n_two = 1'b0;
                    end else begin
                        n_state = r_clr_pend ? S_SWEEP : S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_SWEEP;
                n_swp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_cfg <= CFG_RESET;
            r_prefix <= '0;
            r_pv <= 1'b0;
            r_nf <= (MCB+1)'(FIRST_FREE);
            r_cw <= CWB'(START_WIDTH);
            r_started <= 1'b0;
            r_swp <= '0;
            r_clr_pend <= 1'b1;
            r_two <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_prefix <= n_prefix;
            r_pv <= n_pv;
            r_nf <= n_nf;
            r_cw <= n_cw;
            r_started <= n_started;
            r_swp <= n_swp;
            r_clr_pend <= n_clr_pend;
            r_two <= n_two;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_addr <= n_addr;
        r_probe <= n_probe;
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_code = 12'(r_q0.code);
    assign o_code_width = 4'(r_q0.width);
    assign o_last_of_run = r_q0.last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output sides both open");

    a_second_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_two) |-> !o_last_of_run)
        else $error("first of two codes marked last");

    a_cmp_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_CMP))
        else $error("read not followed by compare");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cw >= CWB'(START_WIDTH)) && (r_cw <= CWB'(MCB)))
        else $error("code width out of range");
endmodule

// File: test/tb_lzw_variable_width_encoder.sv
// Testbench for lzw_variable_width_encoder: directed table then random byte streams,
// checked against a behavioral LZW dictionary predictor. Depends on lzwve_pkg and the RTL.
module tb_lzw_variable_width_encoder
    import lzwve_pkg::*;
();

    localparam int NSLOTS = HASH_SLOTS;
    localparam int WDOG_LIMIT = 60000;

    typedef struct {
        logic [11:0] code;
        logic [3:0]  width;
        logic        last;
    } t_code;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        bit         typed;
        int         n;
        int         c0;
        int         w0;
        int         c1;
        int         w1;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [11:0] o_code;
    logic [3:0]  o_code_width;
    logic        o_last_of_run;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_data = 4'd0;

    lzw_variable_width_encoder u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_data_byte(i_data_byte),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_code(o_code), .o_code_width(o_code_width), .o_last_of_run(o_last_of_run),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    bit          dict_v [NSLOTS];
    logic [11:0] dict_pfx [NSLOTS];
    logic [7:0]  dict_byte [NSLOTS];
    logic [11:0] dict_code [NSLOTS];
    logic [3:0]  max_width_reg = CFG_RESET;
    logic [11:0] pfx;
    bit          pfx_valid;
    int          free_code;
    int          cur_width;
    bit          started;

    t_code exp_codes[$];
    bit    failed = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    idle_cycles = 0;

    function automatic void clear_dict();
        foreach (dict_v[i]) dict_v[i] = 0;
        pfx = '0;
        pfx_valid = 0;
        free_code = int'(FIRST_FREE);
        cur_width = int'(START_WIDTH);
    endfunction

    function automatic int slot_of(logic [11:0] p, logic [7:0] b);
        int unsigned key;
        key = (int'(p) << 8) ^ int'(b);
        key = key ^ (key >> 7);
        return int'(key % NSLOTS);
    endfunction

    function automatic int clamp_width();
        int m;
        m = int'(max_width_reg);
        if (m < int'(START_WIDTH)) m = int'(START_WIDTH);
        if (m > MAX_CODE_BITS) m = MAX_CODE_BITS;
        return m;
    endfunction

    // Runs one item through the LZW dictionary and returns the codes it emits.
    function automatic void lzw_encode(input logic kind, input logic [7:0] b,
                                       output t_code res[$]);
        t_code c;
        int    s;
        bit    hit;
        res = {};
        c.last = 0;
        c.width = cur_width[3:0];
        if (!started) begin
            c.code = CODE_CLR[11:0];
            res.push_back(c);
            started = 1;
        end
        if (kind) begin
            if (pfx_valid) begin
                c.code = pfx;
                res.push_back(c);
            end
            c.code = CODE_EOS[11:0];
            res.push_back(c);
            started = 0;
            clear_dict();
        end else if (!pfx_valid) begin
            pfx = {4'd0, b};
            pfx_valid = 1;
        end else begin
            hit = 0;
            s = slot_of(pfx, b);
            for (int i = 0; i < NSLOTS && dict_v[s]; i++) begin
                if (dict_pfx[s] == pfx && dict_byte[s] == b) begin
                    hit = 1;
                    break;
                end
                s = (s + 1) % NSLOTS;
            end
            if (hit) begin
                pfx = dict_code[s];
            end else begin
                c.code = pfx;
                res.push_back(c);
                // no hit leaves s on the first empty slot of the probe chain, if the chain has one
                if (!dict_v[s]) begin
                    dict_v[s] = 1;
                    dict_pfx[s] = pfx;
                    dict_byte[s] = b;
                    dict_code[s] = free_code[11:0];
                end
                if (free_code == (1 << cur_width)) begin
                    if (cur_width >= clamp_width()) begin
                        c.code = CODE_CLR[11:0];
                        res.push_back(c);
                        clear_dict();
                    end else begin
                        free_code++;
                        cur_width++;
                    end
                end else begin
                    free_code++;
                end
                pfx = {4'd0, b};
                pfx_valid = 1;
            end
        end
        if (res.size() > 0) res[res.size()-1].last = 1;
    endfunction

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_code e;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_codes.size() == 0) begin
                $error("unexpected code transfer: code %0d", o_code);
                failed = 1;
            end else begin
                e = exp_codes.pop_front();
                if (o_code !== e.code) begin
                    $error("code: expected %0d, got %0d", e.code, o_code);
                    failed = 1;
                end
                if (o_code_width !== e.width) begin
                    $error("code_width: expected %0d, got %0d", e.width, o_code_width);
                    failed = 1;
                end
                if (o_last_of_run !== e.last) begin
                    $error("last_of_run: expected %0d, got %0d", e.last, o_last_of_run);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("lzw_variable_width_encoder test failed");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] b,
                             input bit use_typed, input t_code typed_q[$]);
        t_code res[$];
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        lzw_encode(kind, b, res);
        if (use_typed) res = typed_q;
        foreach (res[i]) exp_codes.push_back(res[i]);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_codes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_max_width(input logic [3:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        max_width_reg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    t_row directed[] = '{
        '{1'b0, 8'h00, 1, 1, int'(CODE_CLR), 9, 0, 0},
        '{1'b0, 8'hFF, 1, 1, 0, 9, 0, 0},
        '{1'b1, 8'h00, 1, 2, 255, 9, int'(CODE_EOS), 9},
        '{1'b1, 8'hFF, 1, 2, int'(CODE_CLR), 9, int'(CODE_EOS), 9},
        '{1'b0, 8'h41, 1, 1, int'(CODE_CLR), 9, 0, 0},
        '{1'b0, 8'h41, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'h41, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'h41, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'h41, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'h41, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'h80, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'h7F, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'h55, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'hAA, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'h80, 0, 0, 0, 0, 0, 0},
        '{1'b0, 8'h7F, 0, 0, 0, 0, 0, 0},
        '{1'b1, 8'h00, 0, 0, 0, 0, 0, 0}
    };

    logic [3:0] phase_cfg[8] = '{4'd9, 4'd12, 4'd15, 4'd10, 4'd0, 4'd11, 4'd9, 4'd12};

    initial begin
        t_code typed_q[$];
        t_code c;
        logic  kind;
        logic [7:0] b;
        max_width_reg = CFG_RESET;
        started = 0;
        clear_dict();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            typed_q = {};
            if (directed[r].typed) begin
                c.code = 12'(directed[r].c0);
                c.width = 4'(directed[r].w0);
                c.last = (directed[r].n == 1);
                typed_q.push_back(c);
                if (directed[r].n == 2) begin
                    c.code = 12'(directed[r].c1);
                    c.width = 4'(directed[r].w1);
                    c.last = 1;
                    typed_q.push_back(c);
                end
            end
            send_item(directed[r].kind, directed[r].data, directed[r].typed, typed_q);
        end

        typed_q = {};
        for (int p = 0; p < 8; p++) begin
            write_max_width(phase_cfg[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int k = 0; k < 230; k++) begin
                if (p == 2 && k == 115) drain();
                kind = ($urandom_range(199) == 0);
                if ($urandom_range(9) < 6) b = 8'($urandom_range(255));
                else b = 8'(8'h61 + $urandom_range(3));
                send_item(kind, b, 0, typed_q);
            end
        end
        send_item(1'b1, 8'h00, 0, typed_q);
        i_valid <= 1'b0;

        while (exp_codes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed) $display("lzw_variable_width_encoder test passed");
        else $display("lzw_variable_width_encoder test failed");
        $finish;
    end

endmodule

// File: lzw_variable_width_encoder.f
rtl/lzwve_pkg.sv
rtl/lzwve_dict.sv
rtl/lzw_variable_width_encoder.sv
test/tb_lzw_variable_width_encoder.sv
